[sv/kmdr_pkg.sv]
// shared types, constants and helpers for the keypad matrix scanner
package kmdr_pkg;

	localparam int ROW_COUNT = 4;
	localparam int COL_COUNT = 4;
	localparam int KEY_COUNT = ROW_COUNT * COL_COUNT;
	localparam int KEY_W     = $clog2(KEY_COUNT);
	localparam int ROW_W     = $clog2(ROW_COUNT);
	localparam int COL_W     = $clog2(COL_COUNT);
	localparam int CNT_W     = 13;
	localparam int LIM_W     = 12;
	localparam int CHAR_W    = 7;
	localparam int SLOT_W    = 4;

	localparam int RING_SIZE_DEF = 16;
	localparam int EVQ_DEPTH     = 8;

	localparam int CFG_AW = 4;
	localparam int CFG_DW = 32;

	localparam logic [1:0] REG_FIRST_PRESS = 2'd0;
	localparam logic [1:0] REG_REPEAT_CNT  = 2'd1;
	localparam logic [1:0] REG_REPEAT_DLY  = 2'd2;
	localparam logic [1:0] REG_CHAR_EN     = 2'd3;

	localparam logic [CHAR_W-1:0] CHAR_ZERO = 7'd48;
	localparam logic [CHAR_W-1:0] CHAR_A    = 7'd65;
	localparam logic [KEY_W-1:0]  DIGIT_MAX = 4'd9;

	typedef struct packed {
		logic [COL_W-1:0]     scan_column;
		logic [ROW_COUNT-1:0] row_levels;
	} samp_t;

	typedef struct packed {
		logic [KEY_W-1:0]  key_code;
		logic [CHAR_W-1:0] key_char;
		logic              char_valid;
		logic [SLOT_W-1:0] ring_slot;
		logic              last_event;
	} evt_t;

	typedef struct packed {
		logic [LIM_W-1:0] first_press_count;
		logic [LIM_W-1:0] repeat_count;
		logic [LIM_W-1:0] repeat_delay;
		logic             char_enable;
	} cfg_t;

	typedef struct packed {
		logic [CNT_W-1:0] cnt;
		logic             fired;
	} entry_t;

	function automatic logic [CHAR_W-1:0] hex_char(input logic [KEY_W-1:0] code);
		logic [CHAR_W-1:0] c;
		if (code <= DIGIT_MAX) begin
			c = CHAR_ZERO + {3'b000, code};
		end else begin
			c = CHAR_A + {3'b000, code} - {3'b000, DIGIT_MAX} - 7'd1;
		end
		return c;
	endfunction

endpackage

[sv/keypad_matrix_debounce_repeat.sv]
// top level of the 4x4 keypad scanner with debounce and auto-repeat
//
//  channel  direction  handshake               payload
//  samp     in         samp_valid / samp_stall  scan_column, row_levels
//  evt      out        evt_valid / evt_stall    key_code, key_char, char_valid, ring_slot,
//                                               last_event
//  apb      in/out     psel, penable, pready    4 registers at byte address 4*i
//
// a sample takes one key store access per row, one row per cycle while the queue has room
// events leave through an 8-deep queue, one per cycle while evt_stall is low
// reset clears counters and fired flags at once through per-key valid bits
// a stalled evt side fills the queue; row issue pauses while it lacks room
// a new sample is taken in the cycle its predecessor issues its last row
module keypad_matrix_debounce_repeat #(
	parameter int RING_SIZE = kmdr_pkg::RING_SIZE_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         samp_valid,
	output logic                         samp_stall,
	input  kmdr_pkg::samp_t              samp,
	output logic                         evt_valid,
	input  logic                         evt_stall,
	output kmdr_pkg::evt_t               evt,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kmdr_pkg::CFG_AW-1:0]  paddr,
	input  logic [kmdr_pkg::CFG_DW-1:0]  pwdata,
	output logic [kmdr_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready
);

	localparam int RING_W = (RING_SIZE > 1) ? $clog2(RING_SIZE) : 1;
	localparam int QCW    = $clog2(kmdr_pkg::EVQ_DEPTH + 1);
	localparam logic [kmdr_pkg::ROW_W-1:0] LAST_ROW = kmdr_pkg::ROW_W'(kmdr_pkg::ROW_COUNT - 1);

	kmdr_pkg::cfg_t   cfg;

	// sample buffer and row sequencer
	logic                          buf_v_q;
	kmdr_pkg::samp_t               buf_q;
	logic [kmdr_pkg::ROW_W-1:0]    row_q;
	logic                          issue;
	logic                          space_ok;
	logic [QCW-1:0]                q_count;
	logic [QCW:0]                  need;
	logic [kmdr_pkg::KEY_W-1:0]    rd_addr;

	// stage 1: key entry back from the store
	logic                          valid_s1;
	logic [kmdr_pkg::KEY_W-1:0]    key_s1;
	logic                          hit_s1;
	logic                          lastrow_s1;
	kmdr_pkg::entry_t              ent;
	kmdr_pkg::entry_t              ent_nxt;
	logic [kmdr_pkg::LIM_W-1:0]    thr;
	logic                          below;
	logic                          fire;

	// pending event waits until we know whether it closes the sample
	logic                          pend_v_q;
	logic                          pend_fin_q;
	kmdr_pkg::evt_t                pend_q;
	kmdr_pkg::evt_t                new_evt;
	logic                          push;
	logic                          push_last;
	kmdr_pkg::evt_t                push_data;

	logic [RING_W-1:0]             pos_q;
	logic [RING_W+kmdr_pkg::SLOT_W-1:0] pos_ext;

	kmdr_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// room for the new row plus everything still in flight toward the queue
	assign need     = {1'b0, q_count} + {{QCW{1'b0}}, valid_s1} + {{QCW{1'b0}}, pend_v_q}
	                  + {{QCW{1'b0}}, 1'b1};
	assign space_ok = (need <= (QCW+1)'(kmdr_pkg::EVQ_DEPTH));
	assign issue    = buf_v_q && space_ok;
	// key code is row * cols + column, so the row sits in the high bits
	assign rd_addr  = {row_q, buf_q.scan_column};

	assign samp_stall = buf_v_q && !(issue && (row_q == LAST_ROW));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			buf_v_q <= 1'b0;
			row_q   <= '0;
		end else begin
			if (issue) begin
				row_q <= row_q + 1'b1;
				if (row_q == LAST_ROW) begin
					buf_v_q <= 1'b0;
				end
			end
			if (samp_valid && !samp_stall) begin
				buf_v_q <= 1'b1;
				row_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (samp_valid && !samp_stall) begin
			buf_q <= samp;
		end
	end

	// same key comes back at least four issues later, long after its write
	kmdr_keystore u_store (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (issue),
		.rd_addr (rd_addr),
		.rd_data (ent),
		.wr_en   (valid_s1),
		.wr_addr (key_s1),
		.wr_data (ent_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= issue;
		end
	end

	always_ff @(posedge clk) begin
		if (issue) begin
			key_s1     <= rd_addr;
			hit_s1     <= buf_q.row_levels[row_q];
			lastrow_s1 <= (row_q == LAST_ROW);
		end
	end

	// debounce / repeat decision
	always_comb begin
		thr   = ent.fired ? cfg.repeat_count : cfg.first_press_count;
		below = $signed(ent.cnt) < $signed({1'b0, thr});
		fire  = valid_s1 && hit_s1 && !below;
		if (!hit_s1) begin
			// released key forgets everything
			ent_nxt = '0;
		end else if (below) begin
			ent_nxt.cnt   = ent.cnt + 1'b1;
			ent_nxt.fired = ent.fired;
		end else if (ent.fired) begin
			ent_nxt.cnt   = '0;
			ent_nxt.fired = 1'b1;
		end else begin
			// first acceptance: wait out the repeat delay
			ent_nxt.cnt   = -{1'b0, cfg.repeat_delay};
			ent_nxt.fired = 1'b1;
		end
	end

	assign pos_ext = {{kmdr_pkg::SLOT_W{1'b0}}, pos_q};

	always_comb begin
		new_evt.key_code   = key_s1;
		new_evt.key_char   = kmdr_pkg::hex_char(key_s1);
		new_evt.char_valid = cfg.char_enable;
		new_evt.ring_slot  = pos_ext[kmdr_pkg::SLOT_W-1:0];
		new_evt.last_event = 1'b0;
	end

	// flush the pending event when a newer one arrives, or when the sample ends
	always_comb begin
		if (fire) begin
			push      = pend_v_q;
			push_last = pend_fin_q;
		end else if (valid_s1 && lastrow_s1) begin
			push      = pend_v_q;
			push_last = 1'b1;
		end else begin
			push      = pend_v_q && pend_fin_q;
			push_last = 1'b1;
		end
		push_data            = pend_q;
		push_data.last_event = push_last;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q   <= 1'b0;
			pend_fin_q <= 1'b0;
			pos_q      <= '0;
		end else begin
			if (fire) begin
				pend_v_q   <= 1'b1;
				pend_fin_q <= lastrow_s1;
				pos_q      <= (pos_q == RING_W'(RING_SIZE - 1)) ? '0 : pos_q + 1'b1;
			end else if (push) begin
				pend_v_q   <= 1'b0;
				pend_fin_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (fire) begin
			pend_q <= new_evt;
		end
	end

	kmdr_evq u_evq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.count     (q_count)
	);

endmodule

[sv/kmdr_regs.sv]
// configuration registers behind the apb-style port
module kmdr_regs (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         psel,
	input  logic                         penable,
	input  logic                         pwrite,
	input  logic [kmdr_pkg::CFG_AW-1:0]  paddr,
	input  logic [kmdr_pkg::CFG_DW-1:0]  pwdata,
	output logic [kmdr_pkg::CFG_DW-1:0]  prdata,
	output logic                         pready,
	output kmdr_pkg::cfg_t               cfg
);

	kmdr_pkg::cfg_t cfg_q;
	logic           wr;
	logic [1:0]     idx;

	assign pready = 1'b1;
	assign wr     = psel && penable && pwrite;
	assign idx    = paddr[3:2];
	assign cfg    = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_press_count <= 12'd20;
			cfg_q.repeat_count      <= 12'd5;
			cfg_q.repeat_delay      <= 12'd200;
			cfg_q.char_enable       <= 1'b0;
		end else if (wr) begin
			case (idx)
				kmdr_pkg::REG_FIRST_PRESS: cfg_q.first_press_count <= pwdata[11:0];
				kmdr_pkg::REG_REPEAT_CNT:  cfg_q.repeat_count      <= pwdata[11:0];
				kmdr_pkg::REG_REPEAT_DLY:  cfg_q.repeat_delay      <= pwdata[11:0];
				kmdr_pkg::REG_CHAR_EN:     cfg_q.char_enable       <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (idx)
			kmdr_pkg::REG_FIRST_PRESS: prdata = {20'd0, cfg_q.first_press_count};
			kmdr_pkg::REG_REPEAT_CNT:  prdata = {20'd0, cfg_q.repeat_count};
			kmdr_pkg::REG_REPEAT_DLY:  prdata = {20'd0, cfg_q.repeat_delay};
			kmdr_pkg::REG_CHAR_EN:     prdata = {31'd0, cfg_q.char_enable};
			default:                   prdata = '0;
		endcase
	end

endmodule

[sv/kmdr_keystore.sv]
// per-key counter and fired flag memory with valid bits for reset
module kmdr_keystore (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        rd_en,
	input  logic [kmdr_pkg::KEY_W-1:0]  rd_addr,
	output kmdr_pkg::entry_t            rd_data,
	input  logic                        wr_en,
	input  logic [kmdr_pkg::KEY_W-1:0]  wr_addr,
	input  kmdr_pkg::entry_t            wr_data
);

	kmdr_pkg::entry_t                  mem_q [kmdr_pkg::KEY_COUNT];
	kmdr_pkg::entry_t                  rd_raw_q;
	logic [kmdr_pkg::KEY_COUNT-1:0]    vld_q;
	logic                              rd_vld_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_raw_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q    <= '0;
			rd_vld_q <= 1'b0;
		end else begin
			if (wr_en) begin
				vld_q[wr_addr] <= 1'b1;
			end
			if (rd_en) begin
				rd_vld_q <= vld_q[rd_addr];
			end
		end
	end

	// never-written entry reads as cleared
	assign rd_data = rd_vld_q ? rd_raw_q : '0;

endmodule

[sv/kmdr_evq.sv]
// event queue between the key pipeline and the output channel
module kmdr_evq (
	input  logic                                    clk,
	input  logic                                    arst_n,
	input  logic                                    push,
	input  kmdr_pkg::evt_t                          push_data,
	output logic                                    evt_valid,
	input  logic                                    evt_stall,
	output kmdr_pkg::evt_t                          evt,
	output logic [$clog2(kmdr_pkg::EVQ_DEPTH+1)-1:0] count
);

	localparam int PW = $clog2(kmdr_pkg::EVQ_DEPTH);
	localparam int CW = $clog2(kmdr_pkg::EVQ_DEPTH + 1);

	kmdr_pkg::evt_t  buf_q [kmdr_pkg::EVQ_DEPTH];
	logic [PW-1:0]   wp_q;
	logic [PW-1:0]   rp_q;
	logic [CW-1:0]   cnt_q;
	logic            pop;

	assign evt_valid = (cnt_q != '0);
	assign evt       = buf_q[rp_q];
	assign pop       = evt_valid && !evt_stall;
	assign count     = cnt_q;

	always_ff @(posedge clk) begin
		if (push) begin
			buf_q[wp_q] <= push_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) begin
				wp_q <= (wp_q == PW'(kmdr_pkg::EVQ_DEPTH - 1)) ? '0 : wp_q + 1'b1;
			end
			if (pop) begin
				rp_q <= (rp_q == PW'(kmdr_pkg::EVQ_DEPTH - 1)) ? '0 : rp_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

[tb/tb_keypad_matrix_debounce_repeat.sv]
// self-checking testbench for the 4x4 keypad scanner with debounce and auto-repeat
module tb_keypad_matrix_debounce_repeat;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CLK_HALF     = 10;
	localparam int RING         = kmdr_pkg::RING_SIZE_DEF;
	// a sample walks four rows and the event queue holds 8, so this covers any tail
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 400000;
	localparam int LONG_PRESS   = 24;

	// per-key counter model plus the queue of events still owed by the block
	class key_event_tracker;
		logic [kmdr_pkg::LIM_W-1:0] first_press;
		logic [kmdr_pkg::LIM_W-1:0] repeat_lim;
		logic [kmdr_pkg::LIM_W-1:0] repeat_dly;
		logic                       char_en;
		int                         hold_cnt[kmdr_pkg::KEY_COUNT];
		bit                         fired[kmdr_pkg::KEY_COUNT];
		int                         ring_pos;
		int                         ring_len;
		kmdr_pkg::evt_t             pending_events[$];
		int                         errors;

		function new(int ring_size);
			first_press = 12'd20;
			repeat_lim  = 12'd5;
			repeat_dly  = 12'd200;
			char_en     = 1'b0;
			foreach (hold_cnt[k]) begin
				hold_cnt[k] = 0;
				fired[k]    = 1'b0;
			end
			ring_pos = 0;
			ring_len = ring_size;
			errors   = 0;
		endfunction

		function void set_reg(logic [1:0] idx, logic [kmdr_pkg::CFG_DW-1:0] value);
			case (idx)
				kmdr_pkg::REG_FIRST_PRESS: first_press = value[kmdr_pkg::LIM_W-1:0];
				kmdr_pkg::REG_REPEAT_CNT:  repeat_lim  = value[kmdr_pkg::LIM_W-1:0];
				kmdr_pkg::REG_REPEAT_DLY:  repeat_dly  = value[kmdr_pkg::LIM_W-1:0];
				kmdr_pkg::REG_CHAR_EN:     char_en     = value[0];
				default: ;
			endcase
		endfunction

		function int outstanding();
			return pending_events.size();
		endfunction

		// rows are visited in order, every fired key pushes one event
		function void note_sample(kmdr_pkg::samp_t s);
			kmdr_pkg::evt_t ev;
			int             key;
			int             queued_before;
			bit             at_limit;
			queued_before = pending_events.size();
			for (int r = 0; r < kmdr_pkg::ROW_COUNT; r++) begin
				key = r * kmdr_pkg::COL_COUNT + int'(s.scan_column);
				if (s.row_levels[r]) begin
					if (fired[key])
						at_limit = hold_cnt[key] >= int'(repeat_lim);
					else
						at_limit = hold_cnt[key] >= int'(first_press);
					if (!at_limit) begin
						hold_cnt[key]++;
					end else begin
						ev.key_code = kmdr_pkg::KEY_W'(key);
						if (key < 10)
							ev.key_char = kmdr_pkg::CHAR_W'(int'(kmdr_pkg::CHAR_ZERO) + key);
						else
							ev.key_char = kmdr_pkg::CHAR_W'(int'(kmdr_pkg::CHAR_A) + key - 10);
						ev.char_valid = char_en;
						ev.ring_slot  = kmdr_pkg::SLOT_W'(ring_pos);
						ev.last_event = 1'b0;
						pending_events.push_back(ev);
						// first fire parks the counter at minus the delay, repeats restart at zero
						if (!fired[key]) begin
							hold_cnt[key] = -int'(repeat_dly);
							fired[key]    = 1'b1;
						end else begin
							hold_cnt[key] = 0;
						end
						ring_pos = (ring_pos + 1 >= ring_len) ? 0 : ring_pos + 1;
					end
				end else begin
					fired[key]    = 1'b0;
					hold_cnt[key] = 0;
				end
			end
			if (pending_events.size() > queued_before) begin
				ev = pending_events.pop_back();
				ev.last_event = 1'b1;
				pending_events.push_back(ev);
			end
		endfunction

		function void compare_field(string name, logic [7:0] want, logic [7:0] got);
			if (got !== want) begin
				$display("%0t: %s mismatch, expected %h actual %h", $time, name, want, got);
				errors++;
			end
		endfunction

		function void check_event(kmdr_pkg::evt_t got);
			kmdr_pkg::evt_t want;
			if (pending_events.size() == 0) begin
				$display("%0t: unexpected event, expected none actual %h", $time, got);
				errors++;
				return;
			end
			want = pending_events.pop_front();
			compare_field("key_code", 8'(want.key_code), 8'(got.key_code));
			compare_field("key_char", 8'(want.key_char), 8'(got.key_char));
			compare_field("char_valid", 8'(want.char_valid), 8'(got.char_valid));
			compare_field("ring_slot", 8'(want.ring_slot), 8'(got.ring_slot));
			compare_field("last_event", 8'(want.last_event), 8'(got.last_event));
		endfunction
	endclass

	logic                                clk        = 1'b0;
	logic                                arst_n     = 1'b0;
	logic                                samp_valid = 1'b0;
	logic                                samp_stall;
	kmdr_pkg::samp_t                     samp       = '0;
	logic                                evt_valid;
	logic                                evt_stall  = 1'b0;
	kmdr_pkg::evt_t                      evt;
	logic                                psel       = 1'b0;
	logic                                penable    = 1'b0;
	logic                                pwrite     = 1'b0;
	logic [kmdr_pkg::CFG_AW-1:0]         paddr      = '0;
	logic [kmdr_pkg::CFG_DW-1:0]         pwdata     = '0;
	logic [kmdr_pkg::CFG_DW-1:0]         prdata;
	logic                                pready;

	key_event_tracker                    tracker;
	int                                  send_idle_pct = 0;
	int                                  recv_idle_pct = 0;
	int                                  hold_off_left = 0;
	int unsigned                         cycle_count   = 0;
	// keys currently held down on the simulated pad, one bit per key code
	logic [kmdr_pkg::KEY_COUNT-1:0]      pressed_keys  = '0;
	int                                  scan_pos      = 0;

	keypad_matrix_debounce_repeat #(
		.RING_SIZE(RING)
	) DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.samp_valid(samp_valid),
		.samp_stall(samp_stall),
		.samp      (samp),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #CLK_HALF clk = ~clk;

	// watchdog: a hung handshake or a missing event ends here
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("FAIL");
			$finish;
		end
	end

	// event side: check each accepted beat, then pick the next stall level
	// values read right after the edge are the ones the edge sampled
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && evt_valid && !evt_stall)
				tracker.check_event(evt);
			if (hold_off_left > 0) begin
				// long hold-off so the event queue fills and the sample side stalls
				evt_stall <= 1'b1;
				hold_off_left--;
			end else begin
				evt_stall <= ($urandom_range(99) < recv_idle_pct);
			end
		end
	end

	// one sample beat; random idle cycles ahead of it at the sender's rate
	task automatic send_sample(input kmdr_pkg::samp_t beat);
		while ($urandom_range(99) < send_idle_pct) begin
			samp_valid <= 1'b0;
			@(posedge clk);
		end
		samp_valid <= 1'b1;
		samp       <= beat;
		do @(posedge clk); while (samp_stall);
		tracker.note_sample(beat);
	endtask

	task automatic send_col(input int col, input logic [kmdr_pkg::ROW_COUNT-1:0] rows);
		kmdr_pkg::samp_t beat;
		beat.scan_column = kmdr_pkg::COL_W'(col);
		beat.row_levels  = rows;
		send_sample(beat);
	endtask

	// stop offering samples until every owed event has left the block
	task automatic wait_drained();
		samp_valid <= 1'b0;
		@(posedge clk);
		while (tracker.outstanding() != 0)
			@(posedge clk);
	endtask

	// apb write: setup cycle, then access until pready
	task automatic write_reg(input logic [1:0] idx, input logic [kmdr_pkg::CFG_DW-1:0] value);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= value;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		tracker.set_reg(idx, value);
	endtask

	// registers change only with the block idle: drained plus a quiet tail,
	// since a sample that fires nothing may still be walking its rows
	task automatic configure(input int first, input int rep, input int dly, input bit chr);
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		write_reg(kmdr_pkg::REG_FIRST_PRESS, kmdr_pkg::CFG_DW'(first));
		write_reg(kmdr_pkg::REG_REPEAT_CNT, kmdr_pkg::CFG_DW'(rep));
		write_reg(kmdr_pkg::REG_REPEAT_DLY, kmdr_pkg::CFG_DW'(dly));
		write_reg(kmdr_pkg::REG_CHAR_EN, kmdr_pkg::CFG_DW'(chr));
	endtask

	// realistic scanning: columns in turn, held keys change now and then,
	// with a share of glitchy samples that ignore the scan order
	task automatic run_scan(input int n_items);
		kmdr_pkg::samp_t              beat;
		logic [kmdr_pkg::KEY_W-1:0]   flip;
		for (int i = 0; i < n_items; i++) begin
			if ($urandom_range(99) < 12) begin
				beat.scan_column = kmdr_pkg::COL_W'($urandom_range(kmdr_pkg::COL_COUNT - 1));
				beat.row_levels  = kmdr_pkg::ROW_COUNT'($urandom_range(15));
			end else begin
				if (scan_pos == 0) begin
					if ($urandom_range(99) < 35) begin
						flip = kmdr_pkg::KEY_W'($urandom_range(kmdr_pkg::KEY_COUNT - 1));
						pressed_keys[flip] ^= 1'b1;
					end
					if ($urandom_range(99) < 4)
						pressed_keys = '0;
				end
				beat.scan_column = kmdr_pkg::COL_W'(scan_pos);
				for (int r = 0; r < kmdr_pkg::ROW_COUNT; r++)
					beat.row_levels[r] = pressed_keys[r * kmdr_pkg::COL_COUNT + scan_pos];
				scan_pos = (scan_pos + 1) % kmdr_pkg::COL_COUNT;
			end
			send_sample(beat);
		end
	endtask

	initial begin
		tracker = new(RING);
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles about a third of the time, receiver stalls half the time
		send_idle_pct = 32;
		recv_idle_pct = 50;

		// zero limits: every pressed sample fires, all 16 key characters show up
		configure(0, 0, 0, 1);
		for (int c = 0; c < kmdr_pkg::COL_COUNT; c++)
			send_col(c, 4'b0000);
		for (int c = 0; c < kmdr_pkg::COL_COUNT; c++)
			send_col(c, 4'b1111);
		send_col(2, 4'b0101);
		send_col(1, 4'b1010);
		send_col(1, 4'b0000);

		// fire timing: a key fires one visit after its counter reaches the limit
		configure(1, 1, 2, 0);
		repeat (10) send_col(3, 4'b0001);
		send_col(3, 4'b0000);
		send_col(3, 4'b0001);

		// back pressure: hold the event side while four-event samples keep coming
		configure(0, 0, 0, 1);
		run_scan(40);
		hold_off_left = 120;
		for (int i = 0; i < 30; i++)
			send_col(i % kmdr_pkg::COL_COUNT, 4'b1111);
		// sender waits for every owed event before going on
		wait_drained();
		run_scan(40);

		// roles swapped: receiver stalls less, sender idles half the time
		send_idle_pct = 50;
		recv_idle_pct = 32;
		configure(2, 1, 3, 1);
		run_scan(90);
		configure($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 12),
			1'($urandom_range(0, 1)));
		run_scan(90);

		// full rate both ways
		send_idle_pct = 0;
		recv_idle_pct = 0;
		configure($urandom_range(0, 6), $urandom_range(0, 4), $urandom_range(0, 12),
			1'($urandom_range(0, 1)));
		run_scan(100);

		// register extremes: an instant first fire parks the counter at -4095, next to the bottom
		// of its signed range, then a top first-press limit is never reached
		configure(0, 4095, 4095, 0);
		repeat (LONG_PRESS) send_col(0, 4'b1001);
		send_col(0, 4'b0000);
		configure(4095, 4095, 4095, 1);
		repeat (LONG_PRESS) send_col(1, 4'b0110);
		send_col(1, 4'b0000);

		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (tracker.errors == 0 && tracker.outstanding() == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule

[sim.f]
sv/kmdr_pkg.sv
sv/kmdr_regs.sv
sv/kmdr_keystore.sv
sv/kmdr_evq.sv
sv/keypad_matrix_debounce_repeat.sv
tb/tb_keypad_matrix_debounce_repeat.sv
